// File: rtl/core/lbc_pkg.sv
`timescale 1ns / 1ps
package lbc_pkg;
    localparam int DISK_W  = 4;
    localparam int BLOCK_W = 8;
    localparam int STAMP_W = 32;
    localparam int WORD_W  = 64;
    localparam int IDX_W   = 5;
    localparam int CNT_W   = 32;
    localparam int CFG_W   = 9;

    // operation codes
    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_INSERT = 2'd2;
    localparam logic [1:0] OP_BAD    = 2'd3;

    // configuration register indexes
    localparam logic [0:0] CFG_ENABLED = 1'b0;
    localparam logic [0:0] CFG_ENTRIES = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [DISK_W-1:0]  disk;
        logic [BLOCK_W-1:0] block;
        logic [STAMP_W-1:0] stamp;
    } t_tag;
endpackage

// File: rtl/core/lbc_in_if.sv
`timescale 1ns / 1ps
interface lbc_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic [lbc_pkg::DISK_W-1:0]  disk;
    logic [lbc_pkg::BLOCK_W-1:0] block;
    logic [lbc_pkg::IDX_W-1:0]   word_index;
    logic [lbc_pkg::WORD_W-1:0]  write_word;

    modport source(output valid, op, disk, block, word_index, write_word, input ready);
    modport sink(input valid, op, disk, block, word_index, write_word, output ready);
endinterface

// File: rtl/core/lbc_out_if.sv
`timescale 1ns / 1ps
interface lbc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [lbc_pkg::WORD_W-1:0] read_word;
    logic [lbc_pkg::IDX_W-1:0]  read_index;
    logic                       last;
    logic [lbc_pkg::CNT_W-1:0]  hit_count;
    logic [lbc_pkg::CNT_W-1:0]  query_count;

    modport source(output valid, status, read_word, read_index, last, hit_count, query_count,
                   input ready);
    modport sink(input valid, status, read_word, read_index, last, hit_count, query_count,
                 output ready);
endinterface

// File: rtl/core/lbc_tag_mem.sv
`timescale 1ns / 1ps
module lbc_tag_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  lbc_pkg::t_tag i_wdata,
    input  logic [AW-1:0] i_raddr,
    output lbc_pkg::t_tag o_rdata
);
    lbc_pkg::t_tag r_mem [DEPTH];
    lbc_pkg::t_tag r_rdata;

    // write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/lbc_data_mem.sv
`timescale 1ns / 1ps
module lbc_data_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [lbc_pkg::WORD_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr,
    output logic [lbc_pkg::WORD_W-1:0] o_rdata
);
    logic [lbc_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [lbc_pkg::WORD_W-1:0] r_rdata;

    // write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/core/lru_block_cache_top.sv
`timescale 1ns / 1ps
// Fully associative block cache with least-recently-used replacement.
// Input channel i_in carries one word per item: op, disk, block, word_index
// and write_word. Output channel o_out returns status, read_word, read_index,
// last and the hit and query counters. A lookup hit returns BLOCK_WORDS
// words, last set on the final one; every other item returns one word.
// While enabled and with entries in use, word 0 of an update or insert and
// every lookup scan the tag memory one entry per cycle, set by the single
// read port of the tag memory. Update and insert words after word 0 are
// written to the data memory at accept. A lookup hit then streams its words
// through S_RD and S_LD, one data memory read per word. One item is in
// work at a time; a new item is taken once the previous result sits in the
// output register. After reset, and after enabled is written to 0, a
// clearing pass wipes all MAX_ENTRIES tag entries; no item is taken meanwhile,
// configuration writes are still taken. A stalled receiver holds the output
// word in place and the block waits before loading the next result.
// Configuration: i_cfg_we, i_cfg_index (0 enabled, 1 entries_in_use),
// i_cfg_data; write only while the block is idle.
module lru_block_cache_top #(
    parameter int MAX_ENTRIES = 256,
    parameter int BLOCK_WORDS = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [0:0]                i_cfg_index,
    input  logic [lbc_pkg::CFG_W-1:0] i_cfg_data,
    lbc_in_if.sink                    i_in,
    lbc_out_if.source                 o_out
);
    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int IW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (IW > lbc_pkg::CFG_W) ? IW : lbc_pkg::CFG_W;
    localparam int WW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int DW = SW + WW;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_RD     = 3'd5;
    localparam logic [2:0] S_LD     = 3'd6;

    logic [2:0]                   r_state;
    logic [IW-1:0]                r_idx;
    logic                         r_cmp_vld;
    logic [SW-1:0]                r_cmp_idx;
    logic [SW-1:0]                r_best_idx;
    logic [lbc_pkg::STAMP_W-1:0]  r_best_stamp;
    logic [SW-1:0]                r_slot;
    logic [SW-1:0]                r_open_slot;
    logic                         r_open_ok;
    logic [WW-1:0]                r_k;
    logic [1:0]                   r_op;
    logic [lbc_pkg::DISK_W-1:0]   r_disk;
    logic [lbc_pkg::BLOCK_W-1:0]  r_block;
    logic [lbc_pkg::WORD_W-1:0]   r_wword;
    logic [lbc_pkg::STAMP_W-1:0]  r_stamp;
    logic [lbc_pkg::CNT_W-1:0]    r_hits;
    logic [lbc_pkg::CNT_W-1:0]    r_queries;
    logic                         r_cfg_en;
    logic [lbc_pkg::CFG_W-1:0]    r_cfg_entries;
    logic                         r_res_status;
    logic [lbc_pkg::IDX_W-1:0]    r_res_idx;

    logic                         r_out_valid;
    logic                         r_out_status;
    logic [lbc_pkg::WORD_W-1:0]   r_out_word;
    logic [lbc_pkg::IDX_W-1:0]    r_out_idx;
    logic                         r_out_last;
    logic [lbc_pkg::CNT_W-1:0]    r_out_hits;
    logic [lbc_pkg::CNT_W-1:0]    r_out_queries;

    logic [IW-1:0]                w_used;
    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_out_load;
    logic                         w_cfg_clear;
    logic [6:0]                   w_widx_ext;
    logic                         w_widx_ok;
    logic [6:0]                   w_k_ext;
    logic [lbc_pkg::STAMP_W-1:0]  w_stamp_inc;
    lbc_pkg::t_tag                w_tag_rd;
    lbc_pkg::t_tag                w_tag_wd;
    logic                         w_tag_we;
    logic [SW-1:0]                w_tag_waddr;
    logic                         w_dat_we;
    logic [DW-1:0]                w_dat_waddr;
    logic [lbc_pkg::WORD_W-1:0]   w_dat_wdata;
    logic [lbc_pkg::WORD_W-1:0]   w_dat_rd;
    logic                         w_match;
    logic                         w_cmp_last;
    logic                         w_take_best;
    logic [SW-1:0]                w_nbest_idx;

    // entries in use, capped at the memory depth
    assign w_used = (CW'(r_cfg_entries) > CW'(MAX_ENTRIES)) ? IW'(MAX_ENTRIES)
                                                           : IW'(r_cfg_entries);

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_cfg_clear = i_cfg_we && (i_cfg_index == lbc_pkg::CFG_ENABLED) && !i_cfg_data[0];
    assign w_out_load  = ((r_state == S_EMIT) || (r_state == S_LD)) && w_out_free
                         && !w_cfg_clear;
    assign w_widx_ext  = 7'(i_in.word_index);
    assign w_widx_ok   = w_widx_ext < 7'(BLOCK_WORDS);
    assign w_k_ext     = 7'(r_k);
    assign w_stamp_inc = (&r_stamp) ? r_stamp : r_stamp + 1'b1;

    // compare the entry read in the previous cycle
    assign w_match     = w_tag_rd.valid && (w_tag_rd.disk == r_disk)
                         && (w_tag_rd.block == r_block);
    assign w_cmp_last  = (IW'(r_cmp_idx) + IW'(1)) == w_used;
    assign w_take_best = (r_cmp_idx == '0) || (w_tag_rd.stamp < r_best_stamp);
    assign w_nbest_idx = w_take_best ? r_cmp_idx : r_best_idx;

    // tag write: clearing pass or commit of the chosen entry
    assign w_tag_we    = (r_state == S_CLEAR) || (r_state == S_COMMIT);
    assign w_tag_waddr = (r_state == S_CLEAR) ? r_idx[SW-1:0] : r_slot;
    always_comb begin
        w_tag_wd = '0;
        if (r_state != S_CLEAR) begin
            w_tag_wd.valid = 1'b1;
            w_tag_wd.disk  = r_disk;
            w_tag_wd.block = r_block;
            w_tag_wd.stamp = w_stamp_inc;
        end
    end

    // data write: later words at accept, word 0 at commit
    assign w_dat_we = (w_accept && (i_in.op == lbc_pkg::OP_UPDATE
                                    || i_in.op == lbc_pkg::OP_INSERT)
                       && w_widx_ok && (i_in.word_index != '0) && r_open_ok)
                      || ((r_state == S_COMMIT) && (r_op != lbc_pkg::OP_LOOKUP));
    assign w_dat_waddr = (r_state == S_COMMIT) ? {r_slot, WW'(0)}
                                               : {r_open_slot, w_widx_ext[WW-1:0]};
    assign w_dat_wdata = (r_state == S_COMMIT) ? r_wword : i_in.write_word;

    lbc_tag_mem #(.DEPTH(MAX_ENTRIES), .AW(SW)) u_tag_mem (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (w_tag_waddr),
        .i_wdata (w_tag_wd),
        .i_raddr (r_idx[SW-1:0]),
        .o_rdata (w_tag_rd)
    );

    lbc_data_mem #(.DEPTH(MAX_ENTRIES << WW), .AW(DW)) u_data_mem (
        .i_clk   (i_clk),
        .i_we    (w_dat_we),
        .i_waddr (w_dat_waddr),
        .i_wdata (w_dat_wdata),
        .i_raddr ({r_slot, r_k}),
        .o_rdata (w_dat_rd)
    );

    // hold the output word until taken, then drop it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_open_ok     <= 1'b0;
            r_stamp       <= '0;
            r_hits        <= '0;
            r_queries     <= '0;
            r_cfg_en      <= 1'b0;
            r_cfg_entries <= lbc_pkg::CFG_W'(2);
        end else begin
            // disabling starts a clearing pass
            if (w_cfg_clear) begin
                r_open_ok <= 1'b0;
                r_idx     <= '0;
                r_state   <= S_CLEAR;
            end else begin
                unique case (r_state)
                    S_CLEAR: begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx == IW'(MAX_ENTRIES - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                    S_IDLE: begin
                        if (w_accept) begin
                            r_op      <= i_in.op;
                            r_disk    <= i_in.disk;
                            r_block   <= i_in.block;
                            r_wword   <= i_in.write_word;
                            r_idx     <= '0;
                            r_cmp_vld <= 1'b0;
                            priority if (i_in.op == lbc_pkg::OP_BAD
                                         || (i_in.op != lbc_pkg::OP_LOOKUP && !w_widx_ok)) begin
                                r_res_status <= 1'b1;
                                r_res_idx    <= i_in.word_index;
                                r_state      <= S_EMIT;
                            end else if (i_in.op == lbc_pkg::OP_LOOKUP) begin
                                r_res_status <= 1'b1;
                                r_res_idx    <= '0;
                                if (!r_cfg_en) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_queries <= (&r_queries) ? r_queries : r_queries + 1'b1;
                                    r_state   <= (w_used == '0) ? S_EMIT : S_SCAN;
                                end
                            end else if (i_in.word_index != '0) begin
                                r_res_status <= !r_open_ok;
                                r_res_idx    <= i_in.word_index;
                                r_state      <= S_EMIT;
                            end else begin
                                r_open_ok    <= 1'b0;
                                r_res_status <= 1'b1;
                                r_res_idx    <= '0;
                                r_state      <= (!r_cfg_en || w_used == '0) ? S_EMIT : S_SCAN;
                            end
                        end
                    end
                    S_SCAN: begin
                        // issue the next read while comparing the previous one
                        if (r_idx < w_used) begin
                            r_cmp_vld <= 1'b1;
                            r_cmp_idx <= r_idx[SW-1:0];
                            r_idx     <= r_idx + 1'b1;
                        end else begin
                            r_cmp_vld <= 1'b0;
                        end
                        if (r_cmp_vld) begin
                            if (r_op != lbc_pkg::OP_INSERT) begin
                                if (w_match) begin
                                    r_slot  <= r_cmp_idx;
                                    r_state <= S_COMMIT;
                                end else if (w_cmp_last) begin
                                    r_state <= S_EMIT;
                                end
                            end else begin
                                priority if (!w_tag_rd.valid) begin
                                    r_slot  <= r_cmp_idx;
                                    r_state <= S_COMMIT;
                                end else if (w_match) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_best_idx <= w_nbest_idx;
                                    if (w_take_best) begin
                                        r_best_stamp <= w_tag_rd.stamp;
                                    end
                                    if (w_cmp_last) begin
                                        r_slot  <= w_nbest_idx;
                                        r_state <= S_COMMIT;
                                    end
                                end
                            end
                        end
                    end
                    S_COMMIT: begin
                        r_stamp <= w_stamp_inc;
                        if (r_op != lbc_pkg::OP_INSERT) begin
                            r_hits <= (&r_hits) ? r_hits : r_hits + 1'b1;
                        end
                        if (r_op == lbc_pkg::OP_LOOKUP) begin
                            r_k     <= '0;
                            r_state <= S_RD;
                        end else begin
                            r_open_slot  <= r_slot;
                            r_open_ok    <= 1'b1;
                            r_res_status <= 1'b0;
                            r_state      <= S_EMIT;
                        end
                    end
                    S_EMIT: begin
                        if (w_out_free) begin
                            r_out_status  <= r_res_status;
                            r_out_word    <= '0;
                            r_out_idx     <= r_res_idx;
                            r_out_last    <= 1'b1;
                            r_out_hits    <= r_hits;
                            r_out_queries <= r_queries;
                            r_state       <= S_IDLE;
                        end
                    end
                    S_RD: begin
                        r_state <= S_LD;
                    end
                    S_LD: begin
                        // hold the read word until the output register is free
                        if (w_out_free) begin
                            r_out_status  <= 1'b0;
                            r_out_word    <= w_dat_rd;
                            r_out_idx     <= w_k_ext[lbc_pkg::IDX_W-1:0];
                            r_out_last    <= (r_k == WW'(BLOCK_WORDS - 1));
                            r_out_hits    <= r_hits;
                            r_out_queries <= r_queries;
                            if (r_k == WW'(BLOCK_WORDS - 1)) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_k     <= r_k + 1'b1;
                                r_state <= S_RD;
                            end
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    lbc_pkg::CFG_ENABLED: begin
                        r_cfg_en <= i_cfg_data[0];
                    end
                    lbc_pkg::CFG_ENTRIES: begin
                        r_cfg_entries <= i_cfg_data;
                    end
                endcase
            end
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.read_word   = r_out_word;
    assign o_out.read_index  = r_out_idx;
    assign o_out.last        = r_out_last;
    assign o_out.hit_count   = r_out_hits;
    assign o_out.query_count = r_out_queries;

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("item taken during clearing pass");

    a_open_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open_ok |-> r_cfg_en)
        else $error("slot open while cache disabled");

    a_stream_is_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD || r_state == S_LD) |-> (r_op == lbc_pkg::OP_LOOKUP))
        else $error("data stream for a non-lookup item");

    a_commit_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> $past(r_state) == S_SCAN)
        else $error("commit without a tag scan");
endmodule
